/* design/ecc_pkg.sv */
`default_nettype none

package ecc_pkg;

  localparam int unsigned FLOORS = 4;

  localparam int unsigned DOOR_TICKS_W = 8;
  localparam logic [DOOR_TICKS_W-1:0] DOOR_TICKS_RESET = 8'd3;

  localparam logic [2:0] MODE_HOMING = 3'd0;
  localparam logic [2:0] MODE_IDLE   = 3'd1;
  localparam logic [2:0] MODE_RUN    = 3'd2;
  localparam logic [2:0] MODE_DOOR   = 3'd3;
  localparam logic [2:0] MODE_EMERG  = 3'd4;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic       tick;
    logic [1:0] order_floor;
    logic       order_pending;
    logic       obstruction;
    logic       stop_button;
    logic [1:0] floor_number;
    logic       floor_valid;
  } ecc_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       order_done;
    logic [1:0] floor_indicator;
    logic       stop_lamp;
    logic       door_lamp;
    logic [1:0] motor_direction;
  } ecc_result_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] motor;
    logic       door_lamp;
    logic       stop_lamp;
    logic [1:0] floor_seen;
  } ecc_state_t;

endpackage

`default_nettype wire

/* design/ecc_step.sv */
`default_nettype none

module ecc_step #(
  parameter int unsigned TIMER_BITS = 8
) (
  input  var ecc_pkg::ecc_item_t                   item_i,
  input  var ecc_pkg::ecc_state_t                  state_i,
  input  var logic [TIMER_BITS-1:0]                timer_i,
  input  var logic [ecc_pkg::DOOR_TICKS_W-1:0]     door_ticks_i,
  output ecc_pkg::ecc_state_t                      state_o,
  output logic [TIMER_BITS-1:0]                    timer_o,
  output ecc_pkg::ecc_result_t                     result_o
);

  localparam int unsigned CMP_W =
      (TIMER_BITS > ecc_pkg::DOOR_TICKS_W) ? TIMER_BITS : ecc_pkg::DOOR_TICKS_W;

  logic                  fvalid;
  logic                  here;
  logic                  timed_out;
  logic                  done;
  logic [TIMER_BITS-1:0] tm;
  logic [1:0]            lf;
  ecc_pkg::ecc_state_t   st;

  always_comb begin
    fvalid = item_i.floor_valid && (32'(item_i.floor_number) < ecc_pkg::FLOORS);
    tm     = timer_i;
    if (item_i.tick && (timer_i != {TIMER_BITS{1'b1}})) begin
      tm = timer_i + TIMER_BITS'(1);
    end
    lf        = fvalid ? item_i.floor_number : state_i.floor_seen;
    here      = item_i.order_pending && fvalid && (item_i.floor_number == item_i.order_floor);
    timed_out = CMP_W'(tm) >= CMP_W'(door_ticks_i);
    done      = 1'b0;
    st        = state_i;

    case (state_i.mode)
      ecc_pkg::MODE_IDLE, ecc_pkg::MODE_RUN, ecc_pkg::MODE_DOOR, ecc_pkg::MODE_EMERG: begin
        st.floor_seen = lf;
        if (item_i.stop_button) begin
          // latch the lamps only on entry to emergency
          if (state_i.mode != ecc_pkg::MODE_EMERG) begin
            st.motor     = ecc_pkg::DIR_STOP;
            st.stop_lamp = 1'b1;
            if (fvalid) begin
              st.door_lamp = 1'b1;
            end
          end
          st.mode = ecc_pkg::MODE_EMERG;
        end else if (state_i.mode == ecc_pkg::MODE_EMERG) begin
          st.stop_lamp = 1'b0;
          st.door_lamp = 1'b0;
          st.mode      = ecc_pkg::MODE_IDLE;
        end else if (state_i.mode == ecc_pkg::MODE_DOOR) begin
          if (timed_out && item_i.order_pending) begin
            st.door_lamp = 1'b0;
            st.motor     = (item_i.order_floor < lf) ? ecc_pkg::DIR_DOWN : ecc_pkg::DIR_UP;
            st.mode      = ecc_pkg::MODE_RUN;
          end else if (timed_out) begin
            st.door_lamp = 1'b0;
            st.mode      = ecc_pkg::MODE_IDLE;
          end else begin
            if (item_i.obstruction) begin
              tm = '0;
            end
            // pop the queue head served here and restart the door count
            if (item_i.order_pending && (item_i.order_floor == lf)) begin
              done = 1'b1;
              tm   = '0;
            end
          end
        end else if (here) begin
          st.motor     = ecc_pkg::DIR_STOP;
          st.door_lamp = 1'b1;
          st.mode      = ecc_pkg::MODE_DOOR;
          tm           = '0;
        end else if ((state_i.mode == ecc_pkg::MODE_RUN && fvalid && !item_i.order_pending) ||
                     (state_i.mode == ecc_pkg::MODE_IDLE &&
                      !(item_i.order_pending &&
                        !(fvalid && item_i.floor_number == item_i.order_floor)))) begin
          st.motor = ecc_pkg::DIR_STOP;
          st.mode  = ecc_pkg::MODE_IDLE;
        end else begin
          if (item_i.order_pending) begin
            st.motor = (item_i.order_floor < lf) ? ecc_pkg::DIR_DOWN : ecc_pkg::DIR_UP;
          end else begin
            st.motor = ecc_pkg::DIR_STOP;
          end
          st.mode = ecc_pkg::MODE_RUN;
        end
      end
      default: begin
        // homing, and any unreachable code, drive down to the first floor seen
        st.mode = ecc_pkg::MODE_HOMING;
        if (item_i.stop_button) begin
          st.motor     = ecc_pkg::DIR_STOP;
          st.stop_lamp = 1'b1;
        end else if (fvalid) begin
          st.floor_seen = item_i.floor_number;
          st.motor      = ecc_pkg::DIR_STOP;
          st.stop_lamp  = 1'b0;
          st.mode       = ecc_pkg::MODE_IDLE;
        end else begin
          st.motor     = ecc_pkg::DIR_DOWN;
          st.stop_lamp = 1'b0;
        end
      end
    endcase

    state_o                  = st;
    timer_o                  = tm;
    result_o.motor_direction = st.motor;
    result_o.door_lamp       = st.door_lamp;
    result_o.stop_lamp       = st.stop_lamp;
    result_o.floor_indicator = st.floor_seen;
    result_o.order_done      = done;
    result_o.mode            = st.mode;
  end

endmodule

`default_nettype wire

/* design/elevator_car_controller.sv */
`default_nettype none

// Elevator car controller: one input item per control step, one result item per step, in
// order. An item is registered on acceptance and its result as it advances, which also
// updates the state (mode, last floor, motor, lamps, door timer); a new item is taken
// every cycle unless output backpressure stalls the input register, which holds one
// item. After reset the car drives down until a floor is sensed. The door count lives in
// a TIMER_BITS wide saturating tick counter compared against door_open_ticks, written
// through the cfg port only while the block is idle: a rule for the user, not enforced.
module elevator_car_controller #(
  parameter int unsigned TIMER_BITS = 8
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // [0] floor_valid, [2:1] floor_number, [3] stop_button, [4] obstruction,
  // [5] order_pending, [7:6] order_floor, [8] tick, [15:9] zero
  input  var logic [15:0] s_axis_tdata,
  input  var logic        s_axis_tvalid,
  output logic            s_axis_tready,
  // [1:0] motor_direction, [2] door_lamp, [3] stop_lamp, [5:4] floor_indicator,
  // [6] order_done, [9:7] mode, [15:10] zero
  output logic [15:0]     m_axis_tdata,
  output logic            m_axis_tvalid,
  input  var logic        m_axis_tready,
  input  var logic [7:0]  cfg_data_i,
  input  var logic        cfg_valid_i,
  output logic            cfg_ready_o
);

  logic                                 in_valid_q;
  ecc_pkg::ecc_item_t                   in_item_q;
  logic                                 out_valid_q;
  ecc_pkg::ecc_result_t                 out_res_q;
  ecc_pkg::ecc_result_t                 res_d;
  ecc_pkg::ecc_state_t                  state_q;
  ecc_pkg::ecc_state_t                  state_d;
  logic [TIMER_BITS-1:0]                timer_q;
  logic [TIMER_BITS-1:0]                timer_d;
  logic [ecc_pkg::DOOR_TICKS_W-1:0]     door_ticks_q;
  logic                                 advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q};

  ecc_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .item_i       (in_item_q),
    .state_i      (state_q),
    .timer_i      (timer_q),
    .door_ticks_i (door_ticks_q),
    .state_o      (state_d),
    .timer_o      (timer_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= s_axis_tdata[8:0];
    end
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode       <= ecc_pkg::MODE_HOMING;
      state_q.motor      <= ecc_pkg::DIR_DOWN;
      state_q.door_lamp  <= 1'b0;
      state_q.stop_lamp  <= 1'b0;
      state_q.floor_seen <= 2'd0;
      timer_q            <= '0;
      door_ticks_q       <= ecc_pkg::DOOR_TICKS_RESET;
    end else begin
      if (advance) begin
        state_q <= state_d;
        timer_q <= timer_d;
      end
      if (cfg_valid_i) begin
        door_ticks_q <= cfg_data_i;
      end
    end
  end

  // a pop is only issued with the door open
  a_done_in_door: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.order_done |-> out_res_q.mode == ecc_pkg::MODE_DOOR)
    else $error("order_done outside door mode");

  a_stop_lamp_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stop_lamp |-> state_q.motor == ecc_pkg::DIR_STOP)
    else $error("motor driven with stop lamp lit");

  a_door_lamp_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.door_lamp |-> state_q.motor == ecc_pkg::DIR_STOP)
    else $error("motor driven with door lamp lit");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q) && $stable(state_q))
    else $error("stalled item or state changed");

endmodule

`default_nettype wire

/* sim/ecc_car_checker.sv */
`timescale 1ns / 100ps

module ecc_car_checker (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic [15:0] s_tdata_i,
  input  var logic        s_tvalid_i,
  input  var logic        s_tready_i,
  input  var logic [15:0] m_tdata_i,
  input  var logic        m_tvalid_i,
  input  var logic        m_tready_i,
  input  var logic [7:0]  cfg_data_i,
  input  var logic        cfg_valid_i,
  input  var logic        cfg_ready_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              checked_o,
  output int              pops_o
);

  // Shadow of the car state
  logic [2:0]  car_mode;
  logic [1:0]  car_floor;
  logic [1:0]  car_motor;
  logic [7:0]  door_count;
  logic [7:0]  door_ticks;
  logic        door_on;
  logic        stop_on;

  ecc_pkg::ecc_result_t car_outputs_q[$];
  int          fails = 0;
  int          checked = 0;
  int          pops = 0;

  task automatic go_emergency(input logic at_floor);
    if (car_mode != ecc_pkg::MODE_EMERG) begin
      car_motor = ecc_pkg::DIR_STOP;
      stop_on   = 1'b1;
      if (at_floor) door_on = 1'b1;
    end
    car_mode = ecc_pkg::MODE_EMERG;
  endtask

  task automatic go_run(input logic pend, input logic [1:0] ofl);
    if (car_mode == ecc_pkg::MODE_DOOR) door_on = 1'b0;
    if (car_mode == ecc_pkg::MODE_EMERG) stop_on = 1'b0;
    if (pend) car_motor = (ofl < car_floor) ? ecc_pkg::DIR_DOWN : ecc_pkg::DIR_UP;
    else car_motor = ecc_pkg::DIR_STOP;
    car_mode = ecc_pkg::MODE_RUN;
  endtask

  task automatic go_idle();
    if (car_mode == ecc_pkg::MODE_RUN) car_motor = ecc_pkg::DIR_STOP;
    if (car_mode == ecc_pkg::MODE_DOOR) door_on = 1'b0;
    if (car_mode == ecc_pkg::MODE_EMERG) begin
      stop_on = 1'b0;
      door_on = 1'b0;
    end
    car_mode = ecc_pkg::MODE_IDLE;
  endtask

  task automatic go_door();
    if (car_mode == ecc_pkg::MODE_RUN) car_motor = ecc_pkg::DIR_STOP;
    if (car_mode == ecc_pkg::MODE_EMERG) stop_on = 1'b0;
    door_on    = 1'b1;
    door_count = '0;
    car_mode   = ecc_pkg::MODE_DOOR;
  endtask

  // One control step: update the shadow state and return the outputs it shows
  task automatic advance_car(input ecc_pkg::ecc_item_t it, output ecc_pkg::ecc_result_t res);
    logic sensed;
    logic at_order;
    logic timed_out;
    logic popped;
    sensed = it.floor_valid && (it.floor_number < ecc_pkg::FLOORS);
    popped = 1'b0;
    if (it.tick && door_count != 8'hFF) door_count = door_count + 8'd1;
    if (car_mode == ecc_pkg::MODE_HOMING || car_mode > ecc_pkg::MODE_EMERG) begin
      car_mode = ecc_pkg::MODE_HOMING;
      if (it.stop_button) begin
        car_motor = ecc_pkg::DIR_STOP;
        stop_on   = 1'b1;
      end else if (sensed) begin
        car_floor = it.floor_number;
        car_motor = ecc_pkg::DIR_STOP;
        stop_on   = 1'b0;
        car_mode  = ecc_pkg::MODE_IDLE;
      end else begin
        car_motor = ecc_pkg::DIR_DOWN;
        stop_on   = 1'b0;
      end
    end else begin
      if (sensed) car_floor = it.floor_number;
      at_order  = it.order_pending && sensed && it.floor_number == it.order_floor;
      timed_out = door_count >= door_ticks;
      // stop button wins in every mode
      if (it.stop_button) begin
        go_emergency(sensed);
      end else begin
        case (car_mode)
          ecc_pkg::MODE_RUN: begin
            if (at_order) go_door();
            else if (sensed && !it.order_pending) go_idle();
            else go_run(it.order_pending, it.order_floor);
          end
          ecc_pkg::MODE_IDLE: begin
            if (at_order) go_door();
            else if (it.order_pending && !(sensed && it.floor_number == it.order_floor))
              go_run(it.order_pending, it.order_floor);
            else go_idle();
          end
          ecc_pkg::MODE_DOOR: begin
            if (timed_out && it.order_pending) begin
              go_run(it.order_pending, it.order_floor);
            end else if (timed_out) begin
              go_idle();
            end else begin
              if (it.obstruction) door_count = '0;
              if (it.order_pending && it.order_floor == car_floor) begin
                popped     = 1'b1;
                door_count = '0;
              end
            end
          end
          default: go_idle();
        endcase
      end
    end
    res.motor_direction = car_motor;
    res.door_lamp       = door_on;
    res.stop_lamp       = stop_on;
    res.floor_indicator = car_floor;
    res.order_done      = popped;
    res.mode            = car_mode;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ecc_pkg::ecc_result_t want;
    ecc_pkg::ecc_result_t got;
    if (!rst_ni) begin
      car_mode   = ecc_pkg::MODE_HOMING;
      car_floor  = '0;
      car_motor  = ecc_pkg::DIR_DOWN;
      door_count = '0;
      door_ticks = ecc_pkg::DOOR_TICKS_RESET;
      door_on    = 1'b0;
      stop_on    = 1'b0;
      car_outputs_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) door_ticks = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        advance_car(ecc_pkg::ecc_item_t'(s_tdata_i[8:0]), want);
        car_outputs_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = ecc_pkg::ecc_result_t'(m_tdata_i[9:0]);
        if (got.order_done) pops++;
        if (car_outputs_q.size() == 0) begin
          $error("result item with no step waiting: tdata %h", m_tdata_i);
          fails++;
        end else begin
          want = car_outputs_q.pop_front();
          compare_field("motor_direction", want.motor_direction, got.motor_direction);
          compare_field("door_lamp", want.door_lamp, got.door_lamp);
          compare_field("stop_lamp", want.stop_lamp, got.stop_lamp);
          compare_field("floor_indicator", want.floor_indicator, got.floor_indicator);
          compare_field("order_done", want.order_done, got.order_done);
          compare_field("mode", want.mode, got.mode);
          checked++;
        end
      end
      pending_o <= car_outputs_q.size();
    end
    fail_count_o <= fails;
    checked_o    <= checked;
    pops_o       <= pops;
  end

endmodule

/* sim/elevator_car_controller_tb.sv */
`timescale 1ns / 100ps

module elevator_car_controller_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STEPS_PER_PHASE = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [15:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;

  int fail_count;
  int pending;
  int checked;
  int pops;

  int burst_left = 0;
  int steps_sent = 0;
  int stall_left = 0;
  int stall_style = 0;
  int quiet_cycles = 0;

  logic [7:0] ticks_plan [6] = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd7, 8'd3};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  elevator_car_controller dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tdata  (s_tdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .cfg_data_i    (cfg_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready)
  );

  ecc_car_checker car_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tdata_i    (s_tdata),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .m_tdata_i    (m_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .cfg_data_i   (cfg_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .pops_o       (pops)
  );

  // Receiver: switch between always ready, coin flip and mostly stalled
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_left  <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("elevator_car_controller_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic ecc_pkg::ecc_item_t pack_step(logic fv, logic [1:0] fn, logic stop,
                                                   logic obs, logic pend, logic [1:0] ofl,
                                                   logic tick);
    pack_step = '{tick: tick, order_floor: ofl, order_pending: pend, obstruction: obs,
                  stop_button: stop, floor_number: fn, floor_valid: fv};
  endfunction

  // Mostly plausible traffic: rare stop, live orders, sensor often at the ordered floor
  function automatic ecc_pkg::ecc_item_t random_step();
    ecc_pkg::ecc_item_t it;
    it = ecc_pkg::ecc_item_t'(9'($urandom_range(0, 511)));
    if ($urandom_range(0, 7) != 0) begin
      it.stop_button   = ($urandom_range(0, 19) == 0);
      it.obstruction   = ($urandom_range(0, 7) == 0);
      it.order_pending = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) it.floor_number = it.order_floor;
    end
    return it;
  endfunction

  task automatic send_step(input ecc_pkg::ecc_item_t it);
    s_tdata  <= {7'b0, it};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    steps_sent++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_door_ticks(input logic [7:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // homing, stop while homing, arrive
    send_step(pack_step(0, 0, 0, 0, 0, 0, 0));
    send_step(pack_step(0, 0, 1, 0, 0, 0, 0));
    send_step(pack_step(0, 0, 0, 0, 0, 0, 0));
    send_step(pack_step(1, 2, 0, 0, 0, 0, 0));
    // order above, run up, open door, pop, obstruction, time out
    send_step(pack_step(0, 0, 0, 0, 1, 3, 0));
    send_step(pack_step(0, 0, 0, 0, 1, 3, 1));
    send_step(pack_step(1, 3, 0, 0, 1, 3, 0));
    send_step(pack_step(1, 3, 0, 0, 1, 3, 1));
    send_step(pack_step(1, 3, 0, 1, 0, 0, 1));
    send_step(pack_step(1, 3, 0, 0, 0, 0, 1));
    send_step(pack_step(1, 3, 0, 0, 0, 0, 1));
    send_step(pack_step(1, 3, 0, 0, 0, 0, 1));
    // order below, floor with queue empty, door, stop with door open
    send_step(pack_step(1, 3, 0, 0, 1, 0, 0));
    send_step(pack_step(1, 1, 0, 0, 0, 0, 0));
    send_step(pack_step(1, 1, 0, 0, 1, 1, 0));
    send_step(pack_step(1, 1, 1, 0, 0, 0, 0));
    send_step(pack_step(0, 0, 1, 0, 0, 0, 1));
    send_step(pack_step(0, 0, 0, 0, 0, 0, 0));
    // stop between floors, then run with the queue gone
    send_step(pack_step(0, 0, 0, 0, 1, 2, 0));
    send_step(pack_step(0, 0, 1, 0, 1, 2, 0));
    send_step(pack_step(0, 0, 0, 0, 1, 2, 0));
    send_step(pack_step(0, 0, 0, 0, 1, 2, 0));
    send_step(pack_step(0, 0, 0, 0, 0, 0, 0));
    send_step(pack_step(1, 3, 1, 1, 1, 3, 1));
    send_step(pack_step(0, 0, 0, 0, 0, 0, 0));
    drain();

    ticks_plan[4] = 8'($urandom_range(4, 16));
    foreach (ticks_plan[i]) begin
      write_door_ticks(ticks_plan[i]);
      if (ticks_plan[i] == 8'd255) begin
        // open the door at floor 2 and tick it all the way to saturation
        send_step(pack_step(1, 2, 0, 0, 1, 2, 0));
        send_step(pack_step(1, 2, 0, 0, 1, 2, 0));
        repeat (256) send_step(pack_step(1, 2, 0, 0, 0, 0, 1));
      end
      repeat (STEPS_PER_PHASE) send_step(random_step());
      drain();
    end

    $display("door_open_ticks run at 3, 0, 1, 255, 2, %0d and 3; %0d steps driven",
             ticks_plan[4], steps_sent);
    $display("%0d results compared, %0d queue pops seen", checked, pops);
    if (fail_count == 0) begin
      $display("elevator_car_controller_tb: clean");
    end else begin
      $display("elevator_car_controller_tb: errors");
    end
    $finish;
  end

endmodule
